[hdl/fdsm_pkg.sv]
// Shared constants, field positions and segment decoding for the four-digit display driver.
package fdsm_pkg;

    localparam int DWELL_WIDTH_DEF = 16;
    localparam int CFG_W           = 16;
    localparam int ADDR_W          = 3;
    localparam int VALUE_W         = 24;
    localparam int NUM_W           = 14;

    // Register index, taken from paddr[2].
    localparam logic REG_DWELL = 1'b0;
    localparam logic [CFG_W-1:0] DWELL_RESET = 16'd3;

    localparam logic [7:0] BLANK_CODE = 8'hff;
    localparam int         POINT_BIT  = 7;

    // Output beat layout, lowest bit first.
    localparam int SEG_LSB  = 0;
    localparam int SEG_MSB  = 7;
    localparam int DEN_LSB  = 8;
    localparam int DEN_MSB  = 11;
    localparam int OVER_BIT = 12;
    localparam int OUT_TDATA_W = 16;

    // Range limits of the decimal point selection.
    localparam logic [VALUE_W-1:0] LIM_POINT0 = 24'd10000;
    localparam logic [VALUE_W-1:0] LIM_POINT1 = 24'd100000;
    localparam logic [VALUE_W-1:0] LIM_POINT2 = 24'd1000000;
    localparam logic [NUM_W-1:0]   NUM_MAX    = 14'd9999;

    // Reciprocals scaled by 2^34; exact for every 24-bit input value.
    localparam int          RECIP_W     = 31;
    localparam int          RECIP_SHIFT = 34;
    localparam logic [RECIP_W-1:0] RECIP10   = 31'd1717986919;
    localparam logic [RECIP_W-1:0] RECIP100  = 31'd171798692;
    localparam logic [RECIP_W-1:0] RECIP1000 = 31'd17179870;

    // Reciprocals scaled by 2^24; exact for every 14-bit number.
    localparam int          DIG_SHIFT   = 24;
    localparam logic [20:0] DRECIP10    = 21'd1677722;
    localparam logic [20:0] DRECIP100   = 21'd167773;
    localparam logic [20:0] DRECIP1000  = 21'd16778;

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'hc0;
            4'd1:    code = 8'hf9;
            4'd2:    code = 8'ha4;
            4'd3:    code = 8'hb0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hf8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = BLANK_CODE;
        endcase
        return code;
    endfunction

endpackage

[hdl/four_digit_seven_segment_mux.sv]
// Top level of the multiplexed four-digit seven-segment display driver.
//
// Usage: each input beat is either a load (s_tuser = 0) carrying a value in
// thousandths on s_tdata, or a scan tick (s_tuser = 1). A load picks the
// decimal point by range (d.ddd, dd.dd, ddd.d or a plain integer saturated
// at 9999 with the over-range flag), converts to four digits and stores
// active-low segment codes. A tick advances the scan once the enabled digit
// has been held for dwell_ticks ticks. Every input beat yields exactly one
// output beat with the segments, the active-low digit enable and the flag.
// One beat is taken per cycle unless a stalled receiver backs up the
// pipeline. Stage one registers the input, stage two scales the value with
// one reciprocal multiplier, stage three splits the number into digits and
// updates the display state and the output register.
// Each stage advances whenever the next one is empty or moving, so input
// beats keep being taken into empty stages while an output beat waits; a
// stalled receiver backs the pipeline up and drops s_tready once all three
// stages are full. Reset blanks the display, selects the leftmost digit,
// clears the flag and the dwell counter, and sets dwell_ticks to 3.
module four_digit_seven_segment_mux #(
    parameter int DWELL_WIDTH = fdsm_pkg::DWELL_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fdsm_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fdsm_pkg::VALUE_W-1:0]      s_tdata,   // [23:0] value_milli
    input  logic                              s_tuser,   // [0] req_type
    // Output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] segments, [11:8] digit_enable, [12] over_range, [15:13] zero
    output logic [fdsm_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import fdsm_pkg::*;

    // Configuration
    logic [CFG_W-1:0] dwell_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DWELL);
    assign prdata = (paddr[2] == REG_DWELL) ? {{(32-CFG_W){1'b0}}, dwell_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_reg <= DWELL_RESET;
        end
        else if (cfg_wr)
        begin
            dwell_reg <= pwdata[CFG_W-1:0];
        end
    end

    // Pipeline flow control
    logic a_valid_reg, b_valid_reg, m_valid_reg;
    logic en_a, en_b, en_c;

    assign en_c     = !m_valid_reg || m_tready;
    assign en_b     = !b_valid_reg || en_c;
    assign en_a     = !a_valid_reg || en_b;
    assign s_tready = en_a;
    assign m_tvalid = m_valid_reg;

    // Stage one: input register
    logic               a_req_reg;
    logic [VALUE_W-1:0] a_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en_a)
        begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a && s_tvalid)
        begin
            a_req_reg   <= s_tuser;
            a_value_reg <= s_tdata;
        end
    end

    // Stage two: range selection and scaling to a four-digit number
    logic [RECIP_W-1:0]         recip_sel;
    logic [VALUE_W+RECIP_W-1:0] scaled;
    logic [VALUE_W+RECIP_W-RECIP_SHIFT-1:0] quot;
    logic [NUM_W-1:0]           n_next;
    logic [3:0]                 pt_next;
    logic                       over_next;
    logic                       small_range;

    always_comb
    begin
        small_range = 1'b0;
        pt_next     = 4'b0000;
        recip_sel   = RECIP1000;
        if (a_value_reg < LIM_POINT0)
        begin
            small_range = 1'b1;
            pt_next     = (a_value_reg != '0) ? 4'b0001 : 4'b0000;
        end
        else if (a_value_reg < LIM_POINT1)
        begin
            recip_sel = RECIP10;
            pt_next   = 4'b0010;
        end
        else if (a_value_reg < LIM_POINT2)
        begin
            recip_sel = RECIP100;
            pt_next   = 4'b0100;
        end
    end

    assign scaled = {{RECIP_W{1'b0}}, a_value_reg} * {{VALUE_W{1'b0}}, recip_sel};
    assign quot   = scaled[VALUE_W+RECIP_W-1:RECIP_SHIFT];

    always_comb
    begin
        over_next = 1'b0;
        if (small_range)
        begin
            n_next = a_value_reg[NUM_W-1:0];
        end
        else if (quot > {{($bits(quot)-NUM_W){1'b0}}, NUM_MAX})
        begin
            n_next    = NUM_MAX;
            over_next = 1'b1;
        end
        else
        begin
            n_next = quot[NUM_W-1:0];
        end
    end

    logic             b_req_reg;
    logic [NUM_W-1:0] b_n_reg;
    logic [3:0]       b_pt_reg;
    logic             b_over_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en_b)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b && a_valid_reg)
        begin
            b_req_reg  <= a_req_reg;
            b_n_reg    <= n_next;
            b_pt_reg   <= pt_next;
            b_over_reg <= over_next;
        end
    end

    // Stage three: digit split, display state and output register
    logic [34:0] p1000, p100, p10;
    logic [3:0]  q1000;
    logic [6:0]  q100;
    logic [9:0]  q10;
    logic [3:0]  digit [4];

    assign p1000 = {21'd0, b_n_reg} * {14'd0, DRECIP1000};
    assign p100  = {21'd0, b_n_reg} * {14'd0, DRECIP100};
    assign p10   = {21'd0, b_n_reg} * {14'd0, DRECIP10};
    assign q1000 = p1000[DIG_SHIFT+3:DIG_SHIFT];
    assign q100  = p100[DIG_SHIFT+6:DIG_SHIFT];
    assign q10   = p10[DIG_SHIFT+9:DIG_SHIFT];

    // Each digit is a quotient minus ten times the next coarser quotient.
    logic [6:0]       q1000_x10;
    logic [9:0]       q100_x10;
    logic [NUM_W-1:0] q10_x10;
    logic [6:0]       d1_full;
    logic [9:0]       d2_full;
    logic [NUM_W-1:0] d3_full;

    assign q1000_x10 = {q1000, 3'b000} + {2'b00, q1000, 1'b0};
    assign q100_x10  = {q100, 3'b000} + {2'b00, q100, 1'b0};
    assign q10_x10   = {1'b0, q10, 3'b000} + {3'b000, q10, 1'b0};
    assign d1_full   = q100 - q1000_x10;
    assign d2_full   = q10 - q100_x10;
    assign d3_full   = b_n_reg - q10_x10;
    assign digit[0]  = q1000;
    assign digit[1]  = d1_full[3:0];
    assign digit[2]  = d2_full[3:0];
    assign digit[3]  = d3_full[3:0];

    logic [7:0]             codes_reg  [4];
    logic [7:0]             codes_next [4];
    logic [1:0]             active_reg, active_next;
    logic [DWELL_WIDTH-1:0] cnt_reg, cnt_next;
    logic                   over_reg, over_flag_next;
    logic [CFG_W+DWELL_WIDTH-1:0] dwell_ext;
    logic [DWELL_WIDTH-1:0] limit;
    logic [DWELL_WIDTH-1:0] cnt_inc;
    logic                   step_c;

    assign step_c    = en_c && b_valid_reg;
    assign dwell_ext = {{DWELL_WIDTH{1'b0}}, dwell_reg};
    assign limit     = (dwell_ext[DWELL_WIDTH-1:0] == '0) ? DWELL_WIDTH'(1)
                                                          : dwell_ext[DWELL_WIDTH-1:0];
    assign cnt_inc   = cnt_reg + DWELL_WIDTH'(1);

    always_comb
    begin
        codes_next     = codes_reg;
        active_next    = active_reg;
        cnt_next       = cnt_reg;
        over_flag_next = over_reg;
        if (!b_req_reg)
        begin
            over_flag_next = b_over_reg;
            for (int k = 0; k < 4; k++)
            begin
                codes_next[k] = seg_code(digit[k]);
                codes_next[k][POINT_BIT] = ~b_pt_reg[k];
            end
        end
        else
        begin
            // A counter wrap counts as reaching the limit.
            if (cnt_inc >= limit || cnt_inc == '0)
            begin
                cnt_next    = '0;
                active_next = active_reg + 2'd1;
            end
            else
            begin
                cnt_next = cnt_inc;
            end
        end
    end

    logic [7:0] seg_out_reg;
    logic [3:0] den_out_reg;
    logic       over_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            active_reg  <= 2'd0;
            cnt_reg     <= '0;
            over_reg    <= 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                codes_reg[k] <= BLANK_CODE;
            end
        end
        else
        begin
            if (en_c)
            begin
                m_valid_reg <= b_valid_reg;
            end
            if (step_c)
            begin
                active_reg <= active_next;
                cnt_reg    <= cnt_next;
                over_reg   <= over_flag_next;
                codes_reg  <= codes_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_c)
        begin
            seg_out_reg  <= codes_next[active_next];
            den_out_reg  <= ~(4'b0001 << active_next);
            over_out_reg <= over_flag_next;
        end
    end

    assign m_tdata = {{(OUT_TDATA_W-OVER_BIT-1){1'b0}}, over_out_reg, den_out_reg, seg_out_reg};

endmodule

[hdl/fdsm_checker.sv]
// Port-level checker for the display driver and its bind to the top level.
module fdsm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [fdsm_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import fdsm_pkg::*;

    // A stalled output beat must hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

    // Exactly one digit is enabled, active low.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $countones(m_tdata[DEN_MSB:DEN_LSB]) == 3)
    else $error("digit enable is not one-hot active low");

    // A saturated value is shown as an integer, so no point may be lit.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[OVER_BIT] |-> m_tdata[SEG_LSB+POINT_BIT])
    else $error("decimal point lit on an over-range value");

    // Padding bits of the output beat stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_TDATA_W-1:OVER_BIT+1] == '0)
    else $error("output padding bits are not zero");

endmodule

bind four_digit_seven_segment_mux fdsm_checker u_fdsm_checker (.*);
